// ----- rtl/ect_pkg.sv -----
// Shared types, constants and helper functions for the expression character tokenizer.
// Used by ect_step, expression_char_tokenizer_core and ect_checker. No dependencies.
package ect_pkg;

    // Position counter width; token_start reports it clamped to 16 bits
    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    localparam int KIND_W = 3;
    localparam int MODE_W = 3;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Lexer modes
    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WORD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AMP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PIPE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EQ   = 3'd4;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_WORD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LONE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ANDAND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OROR   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EQEQ   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd6;

    // Characters of interest
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
    localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

    // Lexer state carried from one character to the next
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [POS_BITS-1:0] position;
        logic                held_valid;
        logic [KIND_W-1:0]   held_kind;
        logic [CHAR_W-1:0]   held_char;
        logic [POS_BITS-1:0] held_start;
        logic [LEN_W-1:0]    held_length;
    } t_state;

    // One result beat
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] chr;
        logic [15:0]       start;
        logic [LEN_W-1:0]  length;
        logic [CHAR_W-1:0] look;
        logic              last;
    } t_token;

    // Letters, digits and underscore
    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER);
    endfunction

    // ( ) + - / * . , : ; $ % ^ ! ~
    function automatic logic is_single(input logic [CHAR_W-1:0] c);
        return c inside {8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h2E, 8'h2C,
                         8'h3A, 8'h3B, 8'h24, 8'h25, 8'h5E, 8'h21, 8'h7E};
    endfunction

    // Clamp a stream position to the 16-bit start field
    function automatic logic [15:0] clamp_start(input logic [POS_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

// ----- rtl/ect_step.sv -----
// Combinational lexer step: one character against the current state gives the
// next state and at most one token. Depends on ect_pkg.
module ect_step (
    input  logic [ect_pkg::CHAR_W-1:0] i_ch,
    input  ect_pkg::t_state            i_state,
    output ect_pkg::t_state            o_state,
    output logic                       o_has_result,
    output ect_pkg::t_token            o_result
);

    logic [ect_pkg::MODE_W-1:0] mode;
    logic                       scan_new;
    logic [15:0]                held_start16;
    logic [15:0]                pos16;

    assign held_start16 = ect_pkg::clamp_start(i_state.held_start);
    assign pos16        = ect_pkg::clamp_start(i_state.position);

    always_comb begin
        o_state      = i_state;
        o_has_result = 1'b0;
        o_result     = '0;
        scan_new     = 1'b1;

        // unknown mode codes fall back to idle
        mode = (i_state.mode > ect_pkg::MODE_EQ) ? ect_pkg::MODE_IDLE : i_state.mode;

        // saturating stream position
        if (i_state.position != ect_pkg::POS_MAX) begin
            o_state.position = i_state.position + 1'b1;
        end

        if (i_ch == ect_pkg::CH_NUL) begin
            // end of stream: flush the pending token or give the end marker
            o_has_result  = 1'b1;
            o_result.look = '0;
            o_result.last = 1'b1;
            if (i_state.held_valid) begin
                o_result.kind   = i_state.held_kind;
                o_result.chr    = (i_state.held_kind == ect_pkg::KIND_WORD) ? '0
                                                                            : i_state.held_char;
                o_result.start  = held_start16;
                o_result.length = i_state.held_length;
            end else if (mode == ect_pkg::MODE_WORD) begin
                o_result.kind   = ect_pkg::KIND_WORD;
                o_result.chr    = '0;
                o_result.start  = held_start16;
                o_result.length = i_state.held_length;
            end else if (mode != ect_pkg::MODE_IDLE) begin
                o_result.kind   = ect_pkg::KIND_LONE;
                o_result.chr    = i_state.held_char;
                o_result.start  = held_start16;
                o_result.length = 16'd1;
            end else begin
                o_result.kind   = ect_pkg::KIND_END;
                o_result.chr    = '0;
                o_result.start  = pos16;
                o_result.length = '0;
            end
            o_state = '0;
            scan_new = 1'b0;
        end else begin
            o_result.look = i_ch;
            o_result.last = 1'b0;
            if (i_state.held_valid) begin
                // held terminal goes out with this char as lookahead
                o_has_result      = 1'b1;
                o_result.kind     = i_state.held_kind;
                o_result.chr      = (i_state.held_kind == ect_pkg::KIND_WORD) ? '0
                                                                              : i_state.held_char;
                o_result.start    = held_start16;
                o_result.length   = i_state.held_length;
                o_state.held_valid = 1'b0;
                mode              = ect_pkg::MODE_IDLE;
            end else if (mode == ect_pkg::MODE_WORD) begin
                if (ect_pkg::is_word_char(i_ch)) begin
                    // word grows
                    if (i_state.held_length != ect_pkg::LEN_MAX) begin
                        o_state.held_length = i_state.held_length + 1'b1;
                    end
                    scan_new = 1'b0;
                end else begin
                    o_has_result    = 1'b1;
                    o_result.kind   = ect_pkg::KIND_WORD;
                    o_result.chr    = '0;
                    o_result.start  = held_start16;
                    o_result.length = i_state.held_length;
                    mode            = ect_pkg::MODE_IDLE;
                end
            end else if (mode != ect_pkg::MODE_IDLE) begin
                if (i_ch == i_state.held_char) begin
                    // doubled terminal: hold it for one more char
                    case (mode)
                        ect_pkg::MODE_AMP:  o_state.held_kind = ect_pkg::KIND_ANDAND;
                        ect_pkg::MODE_PIPE: o_state.held_kind = ect_pkg::KIND_OROR;
                        default:            o_state.held_kind = ect_pkg::KIND_EQEQ;
                    endcase
                    o_state.held_length = 16'd2;
                    o_state.held_valid  = 1'b1;
                    mode                = ect_pkg::MODE_IDLE;
                    scan_new            = 1'b0;
                end else begin
                    o_has_result    = 1'b1;
                    o_result.kind   = ect_pkg::KIND_LONE;
                    o_result.chr    = i_state.held_char;
                    o_result.start  = held_start16;
                    o_result.length = 16'd1;
                    mode            = ect_pkg::MODE_IDLE;
                end
            end

            // examine the char as the start of a new token
            if (scan_new) begin
                if ((i_ch == ect_pkg::CH_SPACE) || (i_ch == ect_pkg::CH_TAB)) begin
                    // separator, nothing to do
                end else if (ect_pkg::is_word_char(i_ch)) begin
                    mode                = ect_pkg::MODE_WORD;
                    o_state.held_kind   = ect_pkg::KIND_WORD;
                    o_state.held_char   = '0;
                    o_state.held_start  = i_state.position;
                    o_state.held_length = 16'd1;
                end else if (ect_pkg::is_single(i_ch)) begin
                    o_state.held_valid  = 1'b1;
                    o_state.held_kind   = ect_pkg::KIND_SINGLE;
                    o_state.held_char   = i_ch;
                    o_state.held_start  = i_state.position;
                    o_state.held_length = 16'd1;
                end else if ((i_ch == ect_pkg::CH_AMP) || (i_ch == ect_pkg::CH_PIPE) ||
                             (i_ch == ect_pkg::CH_EQ)) begin
                    mode = (i_ch == ect_pkg::CH_AMP)  ? ect_pkg::MODE_AMP  :
                           (i_ch == ect_pkg::CH_PIPE) ? ect_pkg::MODE_PIPE : ect_pkg::MODE_EQ;
                    o_state.held_kind   = ect_pkg::KIND_LONE;
                    o_state.held_char   = i_ch;
                    o_state.held_start  = i_state.position;
                    o_state.held_length = 16'd1;
                end
            end
            o_state.mode = mode;
        end
    end

endmodule

// ----- rtl/expression_char_tokenizer_core.sv -----
// Expression character tokenizer: top level with input register, lexer state
// and result register. Depends on ect_pkg and ect_step.
//
// Takes one character per beat and returns tokens (words, single terminals,
// lone or doubled &, |, =) with start position, length and one character of
// lookahead; a zero byte ends the stream, always gives one beat with last set,
// and clears the lexer for the next stream. A beat is first held in the input
// register, then the lexer state and the result register update together from
// it, so a result passes through the input register and the result register. One
// beat is taken every cycle while the output side is not stalled; the lexer step
// between the two registers sets that rate. A token is reported when the
// character after it arrives, so most results follow a later input beat.
module expression_char_tokenizer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ect_pkg::CHAR_W-1:0]        i_ch,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ect_pkg::KIND_W-1:0]        o_token_kind,
    output logic [ect_pkg::CHAR_W-1:0]        o_token_char,
    output logic [15:0]                       o_token_start,
    output logic [ect_pkg::LEN_W-1:0]         o_token_length,
    output logic [ect_pkg::CHAR_W-1:0]        o_lookahead,
    output logic                              o_last
);

    logic                       r_in_valid;
    logic [ect_pkg::CHAR_W-1:0] r_in_ch;
    ect_pkg::t_state            r_state;
    logic                       r_out_valid;
    ect_pkg::t_token            r_out;

    ect_pkg::t_state            n_state;
    ect_pkg::t_token            n_out;
    logic                       n_has_result;

    logic out_free;
    logic fire;
    logic in_acc;

    // handshake control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    ect_step u_step (
        .i_ch         (r_in_ch),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_has_result (n_has_result),
        .o_result     (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_ch <= i_ch;
        end
    end

    // lexer state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_state     <= n_state;
            r_out_valid <= n_has_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fire && n_has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_token_kind   = r_out.kind;
    assign o_token_char   = r_out.chr;
    assign o_token_start  = r_out.start;
    assign o_token_length = r_out.length;
    assign o_lookahead    = r_out.look;
    assign o_last         = r_out.last;

endmodule

// ----- rtl/ect_checker.sv -----
// Port-level checker for expression_char_tokenizer_core, bound to the top level.
// Depends on ect_pkg.
module ect_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic [ect_pkg::KIND_W-1:0] o_token_kind,
    input  logic [ect_pkg::CHAR_W-1:0] o_token_char,
    input  logic [15:0]                o_token_start,
    input  logic [ect_pkg::LEN_W-1:0]  o_token_length,
    input  logic [ect_pkg::CHAR_W-1:0] o_lookahead,
    input  logic                       o_last
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    // end marker only on the last beat, empty and without lookahead
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == ect_pkg::KIND_END) |->
            o_last && (o_token_length == '0) && (o_lookahead == '0))
        else $error("malformed end marker");

    // mid-stream tokens carry a nonzero lookahead, the last one carries none
    a_lookahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_lookahead == '0)))
        else $error("lookahead does not match last flag");

    // doubled terminals span two characters
    a_pair_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_token_kind == ect_pkg::KIND_ANDAND) ||
                        (o_token_kind == ect_pkg::KIND_OROR) ||
                        (o_token_kind == ect_pkg::KIND_EQEQ)) |-> (o_token_length == 16'd2))
        else $error("doubled terminal with wrong length");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_token_kind) &&
            $stable(o_token_char) && $stable(o_token_start) && $stable(o_token_length) &&
            $stable(o_lookahead) && $stable(o_last))
        else $error("stalled result beat changed");

endmodule

bind expression_char_tokenizer_core ect_checker u_ect_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_token_kind   (o_token_kind),
    .o_token_char   (o_token_char),
    .o_token_start  (o_token_start),
    .o_token_length (o_token_length),
    .o_lookahead    (o_lookahead),
    .o_last         (o_last)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for expression_char_tokenizer_core: character beats in,
// token beats out, checked against an in-bench lexer model. Depends on ect_pkg.
module tb_top;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [ect_pkg::CHAR_W-1:0]  i_ch = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [ect_pkg::KIND_W-1:0]  o_token_kind;
    logic [ect_pkg::CHAR_W-1:0]  o_token_char;
    logic [15:0]                 o_token_start;
    logic [ect_pkg::LEN_W-1:0]   o_token_length;
    logic [ect_pkg::CHAR_W-1:0]  o_lookahead;
    logic                        o_last;

    expression_char_tokenizer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_ch           (i_ch),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_token_char   (o_token_char),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_lookahead    (o_lookahead),
        .o_last         (o_last)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("FAIL expression_char_tokenizer_core");
        $finish;
    end

    int              errors = 0;
    int              chars_sent = 0;
    int              send_idle_pct = 0;
    int              stall_pct = 0;
    ect_pkg::t_token tokens_due[$];
    ect_pkg::t_state lex;
    string           term_chars = "()+-/*.,:;$%^!~";

    // ---------------------------------------------------------------
    // Lexer model
    // ---------------------------------------------------------------
    function automatic logic word_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == ect_pkg::CH_UNDER;
    endfunction

    function automatic logic term_byte(input logic [7:0] c);
        case (c)
            "(", ")", "+", "-", "/", "*", ".", ",", ":", ";",
            "$", "%", "^", "!", "~": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic ect_pkg::t_token mk_tok(input logic [2:0] k, input logic [7:0] ch,
                                               input logic [15:0] st, input logic [15:0] len,
                                               input logic [7:0] la, input logic lst);
        ect_pkg::t_token t;
        t.kind   = k;
        t.chr    = ch;
        t.start  = st;
        t.length = len;
        t.look   = la;
        t.last   = lst;
        return t;
    endfunction

    function automatic void lex_clear();
        lex = '0;
        lex.mode = ect_pkg::MODE_IDLE;
    endfunction

    // Advance the model by one character; returns 1 when a token comes out
    function automatic logic lex_char(input logic [7:0] c, output ect_pkg::t_token tok);
        logic [ect_pkg::POS_BITS-1:0] p;
        logic [ect_pkg::MODE_W-1:0]   m;
        logic                         got;
        logic [15:0]                  st;
        p   = lex.position;
        m   = (lex.mode > ect_pkg::MODE_EQ) ? ect_pkg::MODE_IDLE : lex.mode;
        got = 1'b0;
        tok = '0;
        st  = ect_pkg::clamp_start(lex.held_start);
        if (lex.position != ect_pkg::POS_MAX) lex.position = lex.position + 1'b1;

        // end of stream: flush whatever is pending, else an end marker
        if (c == ect_pkg::CH_NUL) begin
            if (lex.held_valid)
                tok = mk_tok(lex.held_kind,
                             lex.held_kind == ect_pkg::KIND_WORD ? 8'h00 : lex.held_char,
                             st, lex.held_length, 8'h00, 1'b1);
            else if (m == ect_pkg::MODE_WORD)
                tok = mk_tok(ect_pkg::KIND_WORD, 8'h00, st, lex.held_length, 8'h00, 1'b1);
            else if (m != ect_pkg::MODE_IDLE)
                tok = mk_tok(ect_pkg::KIND_LONE, lex.held_char, st, 16'd1, 8'h00, 1'b1);
            else
                tok = mk_tok(ect_pkg::KIND_END, 8'h00, ect_pkg::clamp_start(p), 16'd0,
                             8'h00, 1'b1);
            lex_clear();
            return 1'b1;
        end

        // close the token in progress, if any
        if (lex.held_valid) begin
            tok = mk_tok(lex.held_kind,
                         lex.held_kind == ect_pkg::KIND_WORD ? 8'h00 : lex.held_char,
                         st, lex.held_length, c, 1'b0);
            lex.held_valid = 1'b0;
            got = 1'b1;
            m = ect_pkg::MODE_IDLE;
        end else if (m == ect_pkg::MODE_WORD) begin
            if (word_byte(c)) begin
                if (lex.held_length != ect_pkg::LEN_MAX)
                    lex.held_length = lex.held_length + 1'b1;
                lex.mode = ect_pkg::MODE_WORD;
                return 1'b0;
            end
            tok = mk_tok(ect_pkg::KIND_WORD, 8'h00, st, lex.held_length, c, 1'b0);
            got = 1'b1;
            m = ect_pkg::MODE_IDLE;
        end else if (m != ect_pkg::MODE_IDLE) begin
            if (c == lex.held_char) begin
                lex.held_kind   = (m == ect_pkg::MODE_AMP)  ? ect_pkg::KIND_ANDAND :
                                  (m == ect_pkg::MODE_PIPE) ? ect_pkg::KIND_OROR :
                                                              ect_pkg::KIND_EQEQ;
                lex.held_length = 16'd2;
                lex.held_valid  = 1'b1;
                lex.mode        = ect_pkg::MODE_IDLE;
                return 1'b0;
            end
            tok = mk_tok(ect_pkg::KIND_LONE, lex.held_char, st, 16'd1, c, 1'b0);
            got = 1'b1;
            m = ect_pkg::MODE_IDLE;
        end

        // start of a new token; blanks and unknown bytes are dropped
        if (c == ect_pkg::CH_SPACE || c == ect_pkg::CH_TAB) begin
        end else if (word_byte(c)) begin
            m = ect_pkg::MODE_WORD;
            lex.held_kind   = ect_pkg::KIND_WORD;
            lex.held_char   = 8'h00;
            lex.held_start  = p;
            lex.held_length = 16'd1;
        end else if (term_byte(c)) begin
            lex.held_valid  = 1'b1;
            lex.held_kind   = ect_pkg::KIND_SINGLE;
            lex.held_char   = c;
            lex.held_start  = p;
            lex.held_length = 16'd1;
        end else if (c == ect_pkg::CH_AMP || c == ect_pkg::CH_PIPE || c == ect_pkg::CH_EQ) begin
            m = (c == ect_pkg::CH_AMP)  ? ect_pkg::MODE_AMP  :
                (c == ect_pkg::CH_PIPE) ? ect_pkg::MODE_PIPE : ect_pkg::MODE_EQ;
            lex.held_kind   = ect_pkg::KIND_LONE;
            lex.held_char   = c;
            lex.held_start  = p;
            lex.held_length = 16'd1;
        end
        lex.mode = m;
        return got;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Output side: random stall, compare each accepted beat with the oldest token due
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        ect_pkg::t_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tokens_due.size() == 0) begin
                report($sformatf("unexpected token beat kind %0d start %0d",
                                 o_token_kind, o_token_start));
            end else begin
                want = tokens_due.pop_front();
                check_field("kind", int'(o_token_kind), int'(want.kind));
                check_field("char", int'(o_token_char), int'(want.chr));
                check_field("start", int'(o_token_start), int'(want.start));
                check_field("length", int'(o_token_length), int'(want.length));
                check_field("lookahead", int'(o_lookahead), int'(want.look));
                check_field("last", int'(o_last), int'(want.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    // Send one character beat; valid stays high afterward until the next call decides
    task automatic send_char(input logic [7:0] c);
        ect_pkg::t_token tok;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        do @(posedge i_clk); while (o_in_stall);
        chars_sent++;
        if (lex_char(c, tok)) tokens_due.push_back(tok);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // Hold the input idle until every predicted token has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tokens_due.size() != 0);
    endtask

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return ect_pkg::CH_UNDER;
    endfunction

    // One random lexeme: mostly well-formed pieces, some noise and early ends
    task automatic send_lexeme();
        int sel;
        int n;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            repeat (n) send_char(rand_word_char());
        end else if (sel < 55) begin
            send_char(term_chars[$urandom_range(0, term_chars.len() - 1)]);
        end else if (sel < 75) begin
            case ($urandom_range(0, 2))
                0: c = ect_pkg::CH_AMP;
                1: c = ect_pkg::CH_PIPE;
                default: c = ect_pkg::CH_EQ;
            endcase
            n = $urandom_range(1, 3);
            repeat (n) send_char(c);
        end else if (sel < 87) begin
            n = $urandom_range(1, 3);
            repeat (n) send_char($urandom_range(0, 1) ? ect_pkg::CH_SPACE : ect_pkg::CH_TAB);
        end else if (sel < 97) begin
            send_char(8'($urandom_range(1, 255)));
        end else begin
            send_char(ect_pkg::CH_NUL);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Words, every terminal class, pairs, triples, tab, unknown byte
    task automatic test_mixed_expression();
        send_text("A9_z==(Zz)&&x||y=b&|!\t~");
        send_char(8'hFF);
        send_text("===");
        send_char(ect_pkg::CH_NUL);
    endtask

    // Each kind of pending token at end of stream, plus empty streams
    task automatic test_stream_ends();
        send_text("a");
        send_char(ect_pkg::CH_NUL);
        send_text("&");
        send_char(ect_pkg::CH_NUL);
        send_text("==");
        send_char(ect_pkg::CH_NUL);
        send_text("(");
        send_char(ect_pkg::CH_NUL);
        send_char(ect_pkg::CH_NUL);
        send_text(" ");
        send_char(ect_pkg::CH_NUL);
        send_char(8'h80);
        send_char(ect_pkg::CH_NUL);
    endtask

    // One long word, then a pair after it
    task automatic test_long_word();
        repeat (80) send_char(rand_word_char());
        send_text(" == ");
        send_char(ect_pkg::CH_NUL);
    endtask

    task automatic test_random(input int idle, input int stall, input int count);
        int goal;
        logic paused;
        send_idle_pct = idle;
        stall_pct     = stall;
        goal          = chars_sent + count;
        paused        = 1'b0;
        while (chars_sent < goal) begin
            send_lexeme();
            if ($urandom_range(0, 11) == 0) send_char(ect_pkg::CH_NUL);
            // sender holds off mid-phase until the output side catches up
            if (!paused && chars_sent >= goal - count / 2) begin
                drain();
                paused = 1'b1;
            end
        end
        send_char(ect_pkg::CH_NUL);
    endtask

    initial begin
        lex_clear();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_mixed_expression();
        test_stream_ends();
        test_long_word();
        test_random(0, 0, 260);
        test_random(65, 0, 260);
        test_random(0, 65, 260);
        test_random(33, 33, 260);

        drain();
        repeat (16) @(posedge i_clk);
        if (errors == 0)
            $display("PASS expression_char_tokenizer_core");
        else
            $display("FAIL expression_char_tokenizer_core");
        $finish;
    end

endmodule
